// ===== src/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants for the track occupancy chain
// Holds the slot count, counter width and the item record that moves
// from cell to cell.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

	// Number of track slots, one cell each
	localparam int TRACK_SLOTS = 64;
	// Width of a running occupancy count (holds 0..TRACK_SLOTS)
	localparam int CNT_W = $clog2(TRACK_SLOTS + 1);
	// Width of reported counts
	localparam int OUT_CNT_W = 7;
	localparam int TIME_W = 32;

	// Item record that moves one cell per cycle while the chain advances
	typedef struct packed {
		logic              vld;
		logic              first;
		logic [TIME_W-1:0] arrive;
		logic [TIME_W-1:0] depart;
		logic              placed;
		logic [CNT_W-1:0]  count;
	} mpd_item_t;

	// Report a count at the output width (wraps like the 7-bit field)
	function automatic logic [OUT_CNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
		logic [CNT_W+OUT_CNT_W-1:0] wide;
		wide = {{OUT_CNT_W{1'b0}}, c};
		return wide[OUT_CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/mpd_cell.sv =====
// ----------------------------------------------------------------------------
// mpd_cell: one track slot of the chain
// Frees its slot on a schedule's first entry or when the held departure is
// strictly before the passing arrival, takes the train if free and unplaced,
// and adds its occupancy to the running count before handing the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_cell import mpd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,       // chain advances this cycle
	input  wire mpd_item_t item_in,
	output mpd_item_t      item_out
);

	logic              occ_q;
	logic [TIME_W-1:0] dep_q;
	mpd_item_t         item_q;

	logic      live;
	logic      keep;
	logic      take;
	logic      occ_next;
	mpd_item_t item_next;

	// Release / take decision for the passing item
	always_comb begin
		live     = occ_q & ~item_in.first;
		keep     = live & ~(dep_q < item_in.arrive);
		take     = ~keep & ~item_in.placed;
		occ_next = keep | take;
		item_next        = item_in;
		item_next.placed = item_in.placed | take;
		item_next.count  = item_in.count + CNT_W'(occ_next);
	end

	// Slot occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (adv && item_in.vld) begin
			occ_q <= occ_next;
		end
	end

	// Held departure, only meaningful while occupied
	always_ff @(posedge clk) begin
		if (adv && item_in.vld && take) begin
			dep_q <= item_in.depart;
		end
	end

	// Hand the item to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (adv) begin
			item_q <= item_in.vld ? item_next : item_in;
		end
	end

	assign item_out = item_q;

endmodule

`default_nettype wire

// ===== src/mpd_result.sv =====
// ----------------------------------------------------------------------------
// mpd_result: running maximum and output register
// Takes items leaving the last cell, tracks the schedule maximum and holds
// the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_result import mpd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mpd_item_t            item_in,
	output logic                      adv,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [OUT_CNT_W-1:0]      occupied,
	output logic [OUT_CNT_W-1:0]      max_out,
	output logic                      ovf
);

	logic             out_valid_q;
	logic [CNT_W-1:0] max_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             first_q;
	logic [CNT_W-1:0] max_next;

	// Chain moves whenever the output register is empty or being drained
	assign adv = ~out_valid_q | out_ready;

	always_comb begin
		if (item_in.first || item_in.count > max_q) begin
			max_next = item_in.count;
		end else begin
			max_next = max_q;
		end
	end

	// Output valid and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			max_q       <= '0;
		end else if (adv) begin
			out_valid_q <= item_in.vld;
			if (item_in.vld) begin
				max_q <= max_next;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv && item_in.vld) begin
			count_q <= item_in.count;
			ovf_q   <= ~item_in.placed;
			first_q <= item_in.first;
		end
	end

	assign out_valid = out_valid_q;
	assign occupied  = to_out_cnt(count_q);
	assign max_out   = to_out_cnt(max_q);
	assign ovf       = ovf_q;

`ifndef NO_ASSERTIONS
	// A dropped train means every slot was held
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ovf_q |-> count_q == CNT_W'(TRACK_SLOTS))
		else $error("overflow reported with a free slot");
	// Maximum never below the current occupancy
	a_max_ge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> max_q >= count_q)
		else $error("running maximum below occupancy");
	// First entry of a schedule restarts the maximum
	a_first_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && first_q |-> max_q == count_q)
		else $error("maximum not restarted on first entry");
	// First entry always finds a slot
	a_first_placed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && first_q |-> !ovf_q && count_q == CNT_W'(1))
		else $error("first entry not placed alone");
`endif

endmodule

`default_nettype wire

// ===== src/min_platforms_by_departure_heap_top.sv =====
// Path: an entry passes 64 cell registers, then one output register, before its result shows.
// Throughput: one entry per cycle unless stalled; cells handle entries in arrival order.
// Backpressure on the result side stalls the whole cell chain together.
// Reset: all slots free, running maximum zero, no result pending.
// ----------------------------------------------------------------------------
// min_platforms_by_departure_heap_top: minimum track count for a schedule
// Entries stream through a row of slot cells; each frees and fills its own
// slot and the occupancy count builds up along the row.
// ----------------------------------------------------------------------------
`default_nettype none

module min_platforms_by_departure_heap_top import mpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] arrive_time, [63:32] depart_time
	input  wire logic        s_axis_tuser,   // [0] first_entry
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [6:0] occupied_tracks, [13:7] max_tracks, pad
	output logic             m_axis_tuser    // [0] overflow
);

	mpd_item_t              chain [TRACK_SLOTS+1];
	logic                   adv;
	logic [OUT_CNT_W-1:0]   occupied;
	logic [OUT_CNT_W-1:0]   max_out;

	// Entry into the first cell
	always_comb begin
		chain[0].vld    = s_axis_tvalid;
		chain[0].first  = s_axis_tuser;
		chain[0].arrive = s_axis_tdata[31:0];
		chain[0].depart = s_axis_tdata[63:32];
		chain[0].placed = 1'b0;
		chain[0].count  = '0;
	end

	assign s_axis_tready = adv;

	// Row of slot cells
	for (genvar g = 0; g < TRACK_SLOTS; g++) begin : g_cell
		mpd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.item_in  (chain[g]),
			.item_out (chain[g+1])
		);
	end

	// Maximum tracking and result register
	mpd_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (chain[TRACK_SLOTS]),
		.adv       (adv),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.occupied  (occupied),
		.max_out   (max_out),
		.ovf       (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, max_out, occupied};

endmodule

`default_nettype wire
